FILE: src/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam int CP_W           = 21;
	localparam int U8D_FIFO_DEPTH = 4;
	localparam logic [CP_W-1:0] REPL_RESET = CP_W'(63);

	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] CONT_MAX  = 8'hBF;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MAX = 8'hF7;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            repl;
		logic            last;
	} result_t;

	typedef struct packed {
		logic [1:0]      count;
		result_t         res1;
		result_t         res0;
		logic [CP_W-1:0] partial;
		logic [1:0]      pending;
	} decode_t;

endpackage

FILE: src/u8d_decode.sv
// ----------------------------------------------------------------------------
// u8d_decode
// Byte classifier and sequence assembler: next state and up to two results.
// ----------------------------------------------------------------------------
module u8d_decode import u8d_pkg::*; (
	input  logic [7:0]      data_byte,
	input  logic            end_of_text,
	input  logic [CP_W-1:0] partial,
	input  logic [1:0]      pending,
	input  logic [CP_W-1:0] repl_char,
	output decode_t         dec
);

	result_t         res [2];
	logic [1:0]      n;
	logic [CP_W-1:0] pv;
	logic [1:0]      pc;
	logic [CP_W-1:0] shifted;

	assign shifted = {partial[CP_W-7:0], data_byte[5:0]};

	always_comb begin
		res[0] = '{cp: repl_char, repl: 1'b1, last: 1'b0};
		res[1] = '{cp: repl_char, repl: 1'b1, last: 1'b0};
		n  = 2'd0;
		pv = partial;
		pc = pending;

		if (data_byte inside {[8'h00:ASCII_MAX]}) begin
			if (pending != 2'd0) begin
				n  = 2'd1;
				pc = 2'd0;
			end
			res[n[0]] = '{cp: CP_W'(data_byte), repl: 1'b0, last: 1'b0};
			n = n + 2'd1;
		end else if (data_byte inside {[8'h80:CONT_MAX]}) begin
			if (pending != 2'd0) begin
				pv = shifted;
				pc = pending - 2'd1;
				if (pc == 2'd0) begin
					res[0] = '{cp: shifted, repl: 1'b0, last: 1'b0};
					n = 2'd1;
				end
			end else begin
				n = 2'd1;
			end
		end else if (data_byte inside {[8'hC0:LEAD2_MAX]}) begin
			pc = 2'd1;
			pv = CP_W'(data_byte[4:0]);
		end else if (data_byte inside {[8'hE0:LEAD3_MAX]}) begin
			pc = 2'd2;
			pv = CP_W'(data_byte[3:0]);
		end else if (data_byte inside {[8'hF0:LEAD4_MAX]}) begin
			pc = 2'd3;
			pv = CP_W'(data_byte[2:0]);
		end else begin
			n  = 2'd1;
			pc = 2'd0;
		end

		if (end_of_text) begin
			if (pc != 2'd0) begin
				res[n[0]] = '{cp: repl_char, repl: 1'b1, last: 1'b0};
				n = n + 2'd1;
			end
			pc = 2'd0;
			pv = '0;
		end

		if (n == 2'd1) res[0].last = 1'b1;
		if (n == 2'd2) res[1].last = 1'b1;

		dec.count   = n;
		dec.res0    = res[0];
		dec.res1    = res[1];
		dec.partial = pv;
		dec.pending = pc;
	end

endmodule

FILE: src/u8d_fifo.sv
// ----------------------------------------------------------------------------
// u8d_fifo
// Result queue: takes up to two results per cycle, delivers one per transfer.
// ----------------------------------------------------------------------------
module u8d_fifo import u8d_pkg::*; #(
	parameter int DEPTH = U8D_FIFO_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  decode_t dec,
	output logic    room2,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t       mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q, wr1, wr2, wr_n;
	logic [CW-1:0] cnt_q;
	logic          pop;
	logic [1:0]    push_n;

	function automatic logic [PW-1:0] incr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr1       = incr(wr_q);
	assign wr2       = incr(wr1);
	assign push_n    = push ? dec.count : 2'd0;
	assign wr_n      = (push_n == 2'd2) ? wr2 : (push_n == 2'd1) ? wr1 : wr_q;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_res   = mem_q[rd_q];
	assign room2     = (cnt_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_q] <= dec.res0;
		if (push_n == 2'd2) mem_q[wr1]  <= dec.res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_n;
			if (pop) rd_q <= incr(rd_q);
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

endmodule

FILE: src/u8d_apb.sv
// ----------------------------------------------------------------------------
// u8d_apb
// APB register slave holding the replacement code point.
// ----------------------------------------------------------------------------
module u8d_apb import u8d_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	output logic [CP_W-1:0] repl_char
);

	logic [CP_W-1:0] repl_q;
	logic            sel0;

	assign sel0      = (paddr[2] == 1'b0);
	assign pready    = 1'b1;
	assign repl_char = repl_q;
	assign prdata    = sel0 ? 32'(repl_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_RESET;
		end else if (psel && penable && pwrite && sel0) begin
			repl_q <= pwdata[CP_W-1:0];
		end
	end

endmodule

FILE: src/utf8_byte_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_top
// Path: byte register, decoder, then the result queue, which drives out_valid.
// Throughput: one byte per cycle while the queue has room for two results;
// a byte giving two results holds the output for two transfers, absorbed by
// the queue. Reset: clears sequence state and queue, repl char returns to '?'.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_top import u8d_pkg::*; #(
	parameter int FIFO_DEPTH = U8D_FIFO_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      data_byte,
	input  logic            end_of_text,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CP_W-1:0] code_point,
	output logic            is_replacement,
	output logic            last_of_run
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            eot_s1;
	logic [CP_W-1:0] partial_q;
	logic [1:0]      pending_q;
	logic [CP_W-1:0] repl_char;
	decode_t         dec;
	logic            room2;
	logic            fire;
	result_t         out_res;

	u8d_apb u_apb (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.repl_char (repl_char)
	);

	assign fire     = valid_s1 && room2;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eot_s1  <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			partial_q <= '0;
			pending_q <= '0;
		end else begin
			if (in_valid && in_ready) valid_s1 <= 1'b1;
			else if (fire)            valid_s1 <= 1'b0;
			if (fire) begin
				partial_q <= dec.partial;
				pending_q <= dec.pending;
			end
		end
	end

	u8d_decode u_decode (
		.data_byte   (byte_s1),
		.end_of_text (eot_s1),
		.partial     (partial_q),
		.pending     (pending_q),
		.repl_char   (repl_char),
		.dec         (dec)
	);

	u8d_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.dec       (dec),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign code_point     = out_res.cp;
	assign is_replacement = out_res.repl;
	assign last_of_run    = out_res.last;

endmodule
